>>> design/assert_macros.svh
// Assertion helpers, clocked on i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/crrg_pkg.sv
package crrg_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned DIAM_W    = 9;
    localparam int unsigned THICK_W   = 9;
    localparam int unsigned CODE_W    = 8;
    localparam int unsigned COORD_W   = 8;
    localparam int unsigned SQ_W      = 17;
    localparam int unsigned DELTA_W   = 11;

    localparam logic [DIAM_W-1:0] DIAM_CAP = 9'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIAMETER  = 3'd0,
        CFG_THICKNESS = 3'd1,
        CFG_HOLLOW    = 3'd2,
        CFG_BLANK     = 3'd3,
        CFG_OUTLINE   = 3'd4,
        CFG_INFILL    = 3'd5
    } t_cfg_idx;

    localparam logic [DIAM_W-1:0]  RST_DIAMETER  = 9'd24;
    localparam logic [THICK_W-1:0] RST_THICKNESS = 9'd1;
    localparam logic [CODE_W-1:0]  RST_BLANK     = 8'd32;
    localparam logic [CODE_W-1:0]  RST_OUTLINE   = 8'd79;
    localparam logic [CODE_W-1:0]  RST_INFILL    = 8'd79;

endpackage

>>> design/circle_ring_raster_generator_unit.sv
// Channel   | Valid        | Flow control | Payload
// ----------+--------------+--------------+--------------------------------------------
// input     | i_in_valid   | o_in_stall   | i_restart
// result    | o_out_valid  | i_out_stall  | o_pixel_code, o_pixel_row, o_pixel_col,
//           |              |              | o_row_end, o_frame_end
// config    | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One pixel per clock while i_out_stall is low; results go via the stage register.
// The walk position advances at input accept; the distance test (two 8-bit squarers,
// one add, two compares) sits between the stage register and the result register.
// Ring bounds d^2 and (d-2t)^2 are squared from the config registers and registered.
// Synchronous reset clears the walk and the valid flags and loads config defaults.
// A stalled result holds; input stalls only when both stages are full and stalled.
// o_cfg_ready is always high.
`include "assert_macros.svh"

module circle_ring_raster_generator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [crrg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [crrg_pkg::DIAM_W-1:0]         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_restart,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [crrg_pkg::CODE_W-1:0]         o_pixel_code,
    output logic [crrg_pkg::COORD_W-1:0]        o_pixel_row,
    output logic [crrg_pkg::COORD_W-1:0]        o_pixel_col,
    output logic                                o_row_end,
    output logic                                o_frame_end
);

    logic [crrg_pkg::DIAM_W-1:0]  r_diameter;
    logic [crrg_pkg::THICK_W-1:0] r_thickness;
    logic                         r_hollow;
    logic [crrg_pkg::CODE_W-1:0]  r_blank;
    logic [crrg_pkg::CODE_W-1:0]  r_outline;
    logic [crrg_pkg::CODE_W-1:0]  r_infill;

    logic [crrg_pkg::DIAM_W-1:0]  d_eff;
    logic [crrg_pkg::DIAM_W-1:0]  d_m1;
    logic [crrg_pkg::DELTA_W-1:0] inner;
    logic [2*crrg_pkg::DIAM_W-1:0] d_sq_full;
    logic [2*crrg_pkg::DIAM_W-1:0] inner_sq_full;
    logic [crrg_pkg::SQ_W-1:0]    r_d_sq;
    logic [crrg_pkg::SQ_W-1:0]    r_inner_sq;
    logic                         r_inner_neg;

    logic [crrg_pkg::COORD_W-1:0] r_row_cnt;
    logic [crrg_pkg::COORD_W-1:0] r_col_cnt;
    logic [crrg_pkg::COORD_W-1:0] n_row_cnt;
    logic [crrg_pkg::COORD_W-1:0] n_col_cnt;
    logic [crrg_pkg::COORD_W-1:0] cur_row;
    logic [crrg_pkg::COORD_W-1:0] cur_col;
    logic                         last_col;
    logic                         last_row;
    logic                         in_acc;

    logic                         r_s1_valid;
    logic [crrg_pkg::COORD_W-1:0] r_s1_row;
    logic [crrg_pkg::COORD_W-1:0] r_s1_col;
    logic                         r_s1_row_end;
    logic                         r_s1_frame_end;
    logic                         s1_adv;

    logic [crrg_pkg::DELTA_W-1:0] di;
    logic [crrg_pkg::DELTA_W-1:0] dj;
    logic [crrg_pkg::DELTA_W-1:0] di_abs;
    logic [crrg_pkg::DELTA_W-1:0] dj_abs;
    logic [2*crrg_pkg::COORD_W-1:0] sq_i;
    logic [2*crrg_pkg::COORD_W-1:0] sq_j;
    logic [crrg_pkg::SQ_W-1:0]    s_sum;
    logic [crrg_pkg::CODE_W-1:0]  code;

    logic                         r_out_valid;
    logic [crrg_pkg::CODE_W-1:0]  r_pixel_code;
    logic [crrg_pkg::COORD_W-1:0] r_pixel_row;
    logic [crrg_pkg::COORD_W-1:0] r_pixel_col;
    logic                         r_row_end;
    logic                         r_frame_end;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diameter  <= crrg_pkg::RST_DIAMETER;
            r_thickness <= crrg_pkg::RST_THICKNESS;
            r_hollow    <= 1'b0;
            r_blank     <= crrg_pkg::RST_BLANK;
            r_outline   <= crrg_pkg::RST_OUTLINE;
            r_infill    <= crrg_pkg::RST_INFILL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                crrg_pkg::CFG_DIAMETER:  r_diameter  <= i_cfg_data;
                crrg_pkg::CFG_THICKNESS: r_thickness <= i_cfg_data;
                crrg_pkg::CFG_HOLLOW:    r_hollow    <= i_cfg_data[0];
                crrg_pkg::CFG_BLANK:     r_blank     <= i_cfg_data[crrg_pkg::CODE_W-1:0];
                crrg_pkg::CFG_OUTLINE:   r_outline   <= i_cfg_data[crrg_pkg::CODE_W-1:0];
                crrg_pkg::CFG_INFILL:    r_infill    <= i_cfg_data[crrg_pkg::CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_diameter == '0) begin
            d_eff = 9'd1;
        end else if (r_diameter > crrg_pkg::DIAM_CAP) begin
            d_eff = crrg_pkg::DIAM_CAP;
        end else begin
            d_eff = r_diameter;
        end
    end

    assign d_m1  = d_eff - 9'd1;
    assign inner = {2'b00, d_eff} - {1'b0, r_thickness, 1'b0};
    assign d_sq_full     = d_eff * d_eff;
    assign inner_sq_full = inner[crrg_pkg::DIAM_W-1:0] * inner[crrg_pkg::DIAM_W-1:0];

    always_ff @(posedge i_clk) begin
        r_d_sq      <= d_sq_full[crrg_pkg::SQ_W-1:0];
        r_inner_sq  <= inner_sq_full[crrg_pkg::SQ_W-1:0];
        r_inner_neg <= inner[crrg_pkg::DELTA_W-1];
    end

    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        if (i_restart || ({1'b0, r_row_cnt} >= d_eff) || ({1'b0, r_col_cnt} >= d_eff)) begin
            cur_row = '0;
            cur_col = '0;
        end else begin
            cur_row = r_row_cnt;
            cur_col = r_col_cnt;
        end
        last_col = ({1'b0, cur_col} == d_m1);
        last_row = ({1'b0, cur_row} == d_m1);
        if (last_col) begin
            n_col_cnt = '0;
            n_row_cnt = last_row ? '0 : cur_row + 8'd1;
        end else begin
            n_col_cnt = cur_col + 8'd1;
            n_row_cnt = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
        end else if (in_acc) begin
            r_row_cnt <= n_row_cnt;
            r_col_cnt <= n_col_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_row       <= cur_row;
            r_s1_col       <= cur_col;
            r_s1_row_end   <= last_col;
            r_s1_frame_end <= last_col && last_row;
        end
    end

    assign di     = {2'b00, r_s1_row, 1'b1} - {2'b00, d_eff};
    assign dj     = {2'b00, r_s1_col, 1'b1} - {2'b00, d_eff};
    assign di_abs = di[crrg_pkg::DELTA_W-1] ? (~di + 11'd1) : di;
    assign dj_abs = dj[crrg_pkg::DELTA_W-1] ? (~dj + 11'd1) : dj;
    assign sq_i   = di_abs[crrg_pkg::COORD_W-1:0] * di_abs[crrg_pkg::COORD_W-1:0];
    assign sq_j   = dj_abs[crrg_pkg::COORD_W-1:0] * dj_abs[crrg_pkg::COORD_W-1:0];
    assign s_sum  = {1'b0, sq_i} + {1'b0, sq_j};

    always_comb begin
        priority if (s_sum > r_d_sq) begin
            code = r_blank;
        end else if (r_inner_neg || (s_sum > r_inner_sq)) begin
            code = r_outline;
        end else begin
            code = r_hollow ? r_blank : r_infill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_pixel_code <= code;
            r_pixel_row  <= r_s1_row;
            r_pixel_col  <= r_s1_col;
            r_row_end    <= r_s1_row_end;
            r_frame_end  <= r_s1_frame_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_code = r_pixel_code;
    assign o_pixel_row  = r_pixel_row;
    assign o_pixel_col  = r_pixel_col;
    assign o_row_end    = r_row_end;
    assign o_frame_end  = r_frame_end;

    `ASSERT_IMP(a_frame_end_corner, o_out_valid && o_frame_end,
        o_row_end && (o_pixel_row == o_pixel_col), "frame end off the last pixel")
    `ASSERT_NEXT(a_s1_hold, r_s1_valid && !s1_adv,
        r_s1_valid && $stable(r_s1_row) && $stable(r_s1_col), "stage lost a held pixel")
    `ASSERT_NEXT(a_restart_origin, in_acc && i_restart,
        r_s1_valid && (r_s1_row == '0) && (r_s1_col == '0), "restart did not return to origin")

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import crrg_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               row_end;
        logic               frame_end;
    } t_pixel;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 3'd7;
    localparam int                   CYCLE_LIMIT    = 1_000_000;
    localparam int                   PRESSURE_PHASE = 9;
    localparam int                   HOLD_CYCLES    = 400;
    localparam int                   RANDOM_ITEMS   = 2000;

    logic                 i_clk;
    logic                 rst_n      = 1'b0;
    logic                 cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [DIAM_W-1:0]    cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_restart = 1'b0;
    logic                 out_stall  = 1'b0;
    logic                 hold_off   = 1'b0;

    logic                 o_cfg_ready;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [CODE_W-1:0]    o_pixel_code;
    logic [COORD_W-1:0]   o_pixel_row;
    logic [COORD_W-1:0]   o_pixel_col;
    logic                 o_row_end;
    logic                 o_frame_end;

    logic [DIAM_W-1:0]    ring_diam;
    logic [THICK_W-1:0]   ring_thick;
    logic                 ring_hollow;
    logic [CODE_W-1:0]    ring_blank;
    logic [CODE_W-1:0]    ring_outline;
    logic [CODE_W-1:0]    ring_infill;
    logic [COORD_W-1:0]   walk_row = '0;
    logic [COORD_W-1:0]   walk_col = '0;

    logic                 pending_restarts[$];
    t_pixel               expected_pixels[$];

    int                   err_cnt         = 0;
    int                   pixels_checked  = 0;
    int                   frames_seen     = 0;
    int                   cycles          = 0;
    int                   phase_no        = 0;
    int unsigned          send_gap        = 0;
    int unsigned          recv_gap        = 0;
    logic                 sender_steady   = 1'b0;
    logic                 receiver_steady = 1'b0;

    circle_ring_raster_generator_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_restart    (in_restart),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_pixel_code (o_pixel_code),
        .o_pixel_row  (o_pixel_row),
        .o_pixel_col  (o_pixel_col),
        .o_row_end    (o_row_end),
        .o_frame_end  (o_frame_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int clamp_diam(input logic [DIAM_W-1:0] raw);
        int d;
        d = int'(raw);
        if (d < 1) d = 1;
        if (d > int'(DIAM_CAP)) d = int'(DIAM_CAP);
        return d;
    endfunction

    function automatic t_pixel predict_pixel(input logic restart);
        int     d;
        int     i;
        int     j;
        int     di;
        int     dj;
        int     dist_sq;
        int     inner;
        t_pixel px;
        d = clamp_diam(ring_diam);
        if (restart || int'(walk_row) >= d || int'(walk_col) >= d) begin
            walk_row = '0;
            walk_col = '0;
        end
        i = int'(walk_row);
        j = int'(walk_col);
        di = 2 * i + 1 - d;
        dj = 2 * j + 1 - d;
        dist_sq = di * di + dj * dj;
        inner = d - 2 * int'(ring_thick);
        if (dist_sq > d * d) begin
            px.code = ring_blank;
        end else if (inner < 0 || dist_sq > inner * inner) begin
            px.code = ring_outline;
        end else begin
            px.code = ring_hollow ? ring_blank : ring_infill;
        end
        px.row       = walk_row;
        px.col       = walk_col;
        px.row_end   = (j == d - 1);
        px.frame_end = (j == d - 1) && (i == d - 1);
        if (px.row_end) begin
            walk_col = '0;
            walk_row = px.frame_end ? '0 : walk_row + 1'b1;
        end else begin
            walk_col = walk_col + 1'b1;
        end
        return px;
    endfunction

    always @(posedge i_clk) begin
        if (!rst_n) begin
            ring_diam    <= RST_DIAMETER;
            ring_thick   <= RST_THICKNESS;
            ring_hollow  <= 1'b0;
            ring_blank   <= RST_BLANK;
            ring_outline <= RST_OUTLINE;
            ring_infill  <= RST_INFILL;
        end else if (cfg_valid && o_cfg_ready) begin
            case (cfg_index)
                CFG_DIAMETER:  ring_diam    <= cfg_data;
                CFG_THICKNESS: ring_thick   <= cfg_data;
                CFG_HOLLOW:    ring_hollow  <= cfg_data[0];
                CFG_BLANK:     ring_blank   <= cfg_data[CODE_W-1:0];
                CFG_OUTLINE:   ring_outline <= cfg_data[CODE_W-1:0];
                CFG_INFILL:    ring_infill  <= cfg_data[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin : drive
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                expected_pixels.push_back(predict_pixel(in_restart));
                void'(pending_restarts.pop_front());
                send_gap = sender_steady ? 0 : idle_len();
            end
            if (in_valid && o_in_stall) begin
                // hold the stalled transaction
            end else if (send_gap != 0) begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_restarts.size() != 0) begin
                in_valid   <= 1'b1;
                in_restart <= pending_restarts[0];
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_pixel want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel at row %0d col %0d", o_pixel_row, o_pixel_col);
                err_cnt++;
            end else begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (o_frame_end) frames_seen++;
                if (o_pixel_code !== want.code) begin
                    $error("pixel_code: expected %0d, got %0d", want.code, o_pixel_code);
                    err_cnt++;
                end
                if (o_pixel_row !== want.row) begin
                    $error("pixel_row: expected %0d, got %0d", want.row, o_pixel_row);
                    err_cnt++;
                end
                if (o_pixel_col !== want.col) begin
                    $error("pixel_col: expected %0d, got %0d", want.col, o_pixel_col);
                    err_cnt++;
                end
                if (o_row_end !== want.row_end) begin
                    $error("row_end: expected %0d, got %0d", want.row_end, o_row_end);
                    err_cnt++;
                end
                if (o_frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0d, got %0d", want.frame_end, o_frame_end);
                    err_cnt++;
                end
            end
        end
        if (hold_off) begin
            out_stall <= 1'b1;
        end else if (recv_gap != 0) begin
            recv_gap = recv_gap - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
            recv_gap = receiver_steady ? 0 : idle_len();
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin : receiver_hold
        wait (phase_no == PRESSURE_PHASE);
        repeat (20) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIAM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_config(input logic [DIAM_W-1:0] diam, input logic [DIAM_W-1:0] thick,
                              input logic [DIAM_W-1:0] hollow, input logic [DIAM_W-1:0] blank,
                              input logic [DIAM_W-1:0] outline, input logic [DIAM_W-1:0] infill);
        cfg_write(CFG_DIAMETER, diam);
        cfg_write(CFG_THICKNESS, thick);
        cfg_write(CFG_HOLLOW, hollow);
        cfg_write(CFG_BLANK, blank);
        cfg_write(CFG_OUTLINE, outline);
        cfg_write(CFG_INFILL, infill);
        cfg_valid <= 1'b0;
        repeat (3) @(posedge i_clk);
    endtask

    task automatic push_items(input int n, input int restart_pct);
        for (int k = 0; k < n; k++) begin
            pending_restarts.push_back($urandom_range(0, 99) < restart_pct);
        end
    endtask

    task automatic drain();
        while (pending_restarts.size() != 0 || expected_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : sequencer
        int          random_items;
        int          n;
        int          d_eff;
        int          frame;
        int          restart_pct;
        int unsigned r;
        logic [DIAM_W-1:0] diam;
        logic [DIAM_W-1:0] thick;

        random_items = 0;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        pending_restarts.push_back(1'b0);
        pending_restarts.push_back(1'b0);
        pending_restarts.push_back(1'b1);
        pending_restarts.push_back(1'b0);
        drain();

        phase_no = 1;
        cfg_write(CFG_UNUSED, 9'h1ff);
        set_config(9'd0, 9'd0, 9'd0, 9'd0, 9'd255, 9'd170);
        push_items(3, 50);
        drain();

        phase_no = 2;
        set_config(9'd511, 9'd256, 9'd1, 9'd255, 9'd0, 9'd85);
        push_items(3, 0);
        drain();

        // walk sits past the new edge: expect a wrap to the origin
        phase_no = 3;
        set_config(9'd2, 9'd1, 9'd0, 9'd1, 9'd2, 9'd3);
        push_items(5, 0);
        drain();

        phase_no = 4;
        set_config(9'd3, 9'd2, 9'd0, 9'd10, 9'd20, 9'd30);
        push_items(9, 0);
        drain();

        phase_no = 5;
        set_config(9'd256, 9'd0, 9'd0, 9'd0, 9'd255, 9'd255);
        push_items(300, 0);
        random_items += 300;
        drain();

        phase_no = 6;
        set_config(9'd256, 9'd256, 9'd1, 9'd511, 9'd256, 9'd0);
        push_items(200, 1);
        random_items += 200;
        drain();

        phase_no = 7;
        set_config(9'd1, 9'd256, 9'd1, 9'd0, 9'd0, 9'd0);
        push_items(40, 10);
        random_items += 40;
        drain();

        while (random_items < RANDOM_ITEMS) begin
            phase_no++;
            r = $urandom_range(0, 9);
            if (r < 6) begin
                diam = DIAM_W'($urandom_range(1, 16));
            end else if (r < 8) begin
                diam = DIAM_W'($urandom_range(17, 40));
            end else if (r == 8) begin
                diam = DIAM_W'($urandom_range(41, 255));
            end else begin
                case ($urandom_range(0, 2))
                    0:       diam = 9'd0;
                    1:       diam = 9'd256;
                    default: diam = DIAM_W'($urandom_range(257, 511));
                endcase
            end
            d_eff = clamp_diam(diam);
            if ($urandom_range(0, 4) == 0) thick = DIAM_W'($urandom_range(0, 511));
            else thick = DIAM_W'($urandom_range(0, d_eff / 2 + 1));
            frame = d_eff * d_eff;
            if (frame <= 150) n = frame * $urandom_range(1, 300 / frame);
            else n = $urandom_range(100, 300);
            case ($urandom_range(0, 9))
                0:       restart_pct = 30;
                1, 2, 3: restart_pct = 0;
                default: restart_pct = 2;
            endcase
            sender_steady   = ($urandom_range(0, 4) == 0);
            receiver_steady = ($urandom_range(0, 4) == 0);
            if (phase_no == PRESSURE_PHASE) begin
                sender_steady = 1'b1;
                if (n < 500) n = 500;
            end
            set_config(diam, thick, DIAM_W'($urandom_range(0, 511)),
                       DIAM_W'($urandom_range(0, 511)), DIAM_W'($urandom_range(0, 511)),
                       DIAM_W'($urandom_range(0, 511)));
            push_items(n, restart_pct);
            random_items += n;
            drain();
        end

        repeat (6) @(posedge i_clk);
        $display("summary: %0d pixels checked in %0d frames over %0d configuration phases",
                 pixels_checked, frames_seen, phase_no + 1);
        $display("summary: diameters 0 to 511, thin and thick rings, restarts, long output hold");
        if (err_cnt == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
